[src/lbp3r_pkg.sv]
// shared types, constants and the pattern function of the 3x3 lbp raster operator
`default_nettype none

package lbp3r_pkg;

    localparam int PIXEL_W    = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // per-pixel decisions taken when the pixel enters
    typedef struct packed {
        logic emit;
        logic interior;
        logic is_last;
    } pix_flags_t;

    // one line store word: column value two rows up and one row up
    typedef struct packed {
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
    } col_word_t;

    // 3x3 window, row-major, top row first
    typedef logic [8:0][PIXEL_W-1:0] win_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] code;
        logic               last;
    } out_item_t;

    // bits 7..0: nw, n, ne, e, se, s, sw, w strictly greater than centre
    function automatic logic [PIXEL_W-1:0] lbp_code(input win_t win);
        logic [PIXEL_W-1:0] c;
        c = win[4];
        return {win[0] > c, win[1] > c, win[2] > c, win[5] > c,
                win[8] > c, win[7] > c, win[6] > c, win[3] > c};
    endfunction

endpackage

`default_nettype wire

[src/lbp3r_stream_ctrl.sv]
// configuration registers, stream position counters and the entry stage register
`default_nettype none

module lbp3r_stream_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [lbp3r_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lbp3r_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic [lbp3r_pkg::PIXEL_W-1:0]        pixel,
    input  wire logic                                 flush,
    output logic                                      step,
    output logic [$clog2(MAX_WIDTH)-1:0]              step_addr,
    output logic                                      s1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]              s1_addr,
    output logic [lbp3r_pkg::PIXEL_W-1:0]             s1_pixel,
    output lbp3r_pkg::pix_flags_t                     s1_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > lbp3r_pkg::WIDTH_W) ? WW : lbp3r_pkg::WIDTH_W;
    localparam int ROW_W = lbp3r_pkg::HEIGHT_W + 1;

    logic [lbp3r_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [lbp3r_pkg::HEIGHT_W-1:0] image_height_reg;
    logic [COL_W-1:0]               in_column_reg, in_column_next;
    logic [ROW_W-1:0]               in_row_reg, in_row_next;
    logic [COL_W-1:0]               out_column_reg, out_column_next;
    logic [lbp3r_pkg::HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic                 s1_valid_reg;
    logic [COL_W-1:0]     s1_addr_reg;
    logic [lbp3r_pkg::PIXEL_W-1:0] s1_pixel_reg;
    lbp3r_pkg::pix_flags_t s1_flags_reg;

    logic [CMP_W-1:0]    width_ext;
    logic [WW-1:0]       eff_width;
    logic [WW:0]         eff_width_ext;
    logic [lbp3r_pkg::HEIGHT_W-1:0] eff_height;
    logic [ROW_W-1:0]    height_ext;
    logic [WW-1:0]       in_col_inc;
    logic                in_col_wrap;
    logic [WW:0]         out_col_ext;
    logic [WW:0]         out_col_inc;
    logic                out_col_wrap;
    logic [ROW_W-1:0]    out_row_ext;
    logic                cfg_write;
    logic                restart;
    logic                at_start;
    logic                past_end;
    lbp3r_pkg::pix_flags_t flags;
    logic [lbp3r_pkg::PIXEL_W-1:0] step_pixel;

    // effective frame size: zero acts as one, width clamps to the line store
    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        priority if (width_ext == '0)
            eff_width = WW'(1);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_ext);
        eff_height = (image_height_reg == '0) ? lbp3r_pkg::HEIGHT_W'(1) : image_height_reg;
    end

    assign eff_width_ext = (WW+1)'(eff_width);
    assign height_ext    = ROW_W'(eff_height);

    assign in_col_inc  = WW'(in_column_reg) + WW'(1);
    assign in_col_wrap = in_col_inc >= eff_width;
    assign out_col_ext = (WW+1)'(out_column_reg);
    assign out_col_inc = out_col_ext + (WW+1)'(1);
    assign out_col_wrap = out_col_inc >= eff_width_ext;
    assign out_row_ext = ROW_W'(out_row_reg);

    assign at_start = (in_row_reg == '0) && (in_column_reg == '0);
    assign past_end = in_row_reg >= height_ext;
    assign step     = in_valid && !in_stall && !(flush && at_start);
    assign step_addr = in_column_reg;
    assign step_pixel = (flush || past_end) ? '0 : pixel;

    always_comb
    begin
        flags.emit = (in_row_reg >= ROW_W'(2))
                     || ((in_row_reg == ROW_W'(1)) && (in_column_reg != '0));
        flags.interior = (out_row_reg != '0)
                         && ((out_row_ext + ROW_W'(2)) <= height_ext)
                         && (out_column_reg != '0)
                         && ((out_col_ext + (WW+1)'(2)) <= eff_width_ext);
        flags.is_last = ((out_row_ext + ROW_W'(1)) >= height_ext) && out_col_wrap;
    end

    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                lbp3r_pkg::CFG_IMAGE_WIDTH:  restart = 1'b1;
                lbp3r_pkg::CFG_IMAGE_HEIGHT: restart = 1'b1;
                default:                     restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        priority if (restart)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
        else if (step)
        begin
            if (flags.emit && flags.is_last)
            begin
                in_column_next  = '0;
                in_row_next     = '0;
                out_column_next = '0;
                out_row_next    = '0;
            end
            else
            begin
                if (flags.emit)
                begin
                    if (out_col_wrap)
                    begin
                        out_column_next = '0;
                        out_row_next    = out_row_reg + lbp3r_pkg::HEIGHT_W'(1);
                    end
                    else
                    begin
                        out_column_next = out_col_inc[COL_W-1:0];
                    end
                end
                if (in_col_wrap)
                begin
                    in_column_next = '0;
                    in_row_next    = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_column_next = in_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= lbp3r_pkg::WIDTH_RESET;
            image_height_reg <= lbp3r_pkg::HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == lbp3r_pkg::CFG_IMAGE_WIDTH))
                image_width_reg <= cfg_data[lbp3r_pkg::WIDTH_W-1:0];
            if (cfg_write && (cfg_index == lbp3r_pkg::CFG_IMAGE_HEIGHT))
                image_height_reg <= cfg_data[lbp3r_pkg::HEIGHT_W-1:0];
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            s1_valid_reg   <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_addr_reg  <= in_column_reg;
            s1_pixel_reg <= step_pixel;
            s1_flags_reg <= flags;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pixel = s1_pixel_reg;
    assign s1_flags = s1_flags_reg;

endmodule

`default_nettype wire

[src/lbp3r_line_store.sv]
// two-row line store memory with same-column bypass
`default_nettype none

module lbp3r_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
    input  wire logic [lbp3r_pkg::PIXEL_W-1:0]     wr_pixel,
    output lbp3r_pkg::col_word_t                   col_word
);

    lbp3r_pkg::col_word_t mem [MAX_WIDTH];
    lbp3r_pkg::col_word_t rdata_reg;
    lbp3r_pkg::col_word_t fwd_data_reg;
    logic                 fwd_valid_reg;
    lbp3r_pkg::col_word_t word_eff;
    lbp3r_pkg::col_word_t wr_word;

    // a read in the same cycle as a write to that column sees the new word
    assign word_eff = fwd_valid_reg ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        wr_word.top = word_eff.mid;
        wr_word.mid = wr_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
        fwd_data_reg <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else
            fwd_valid_reg <= rd_en && wr_en && (rd_addr == wr_addr);
    end

    assign col_word = word_eff;

endmodule

`default_nettype wire

[src/lbp3r_window.sv]
// 3x3 window registers and pattern / pass-through result
`default_nettype none

module lbp3r_window (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift_en,
    input  lbp3r_pkg::pix_flags_t              flags,
    input  wire logic [lbp3r_pkg::PIXEL_W-1:0] pixel,
    input  lbp3r_pkg::col_word_t               col_word,
    output logic                               push,
    output lbp3r_pkg::out_item_t               result
);

    lbp3r_pkg::win_t window_reg;
    lbp3r_pkg::win_t window_next;

    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = col_word.top;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = col_word.mid;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (shift_en)
            window_reg <= window_next;
    end

    assign push = shift_en && flags.emit;

    always_comb
    begin
        result.code = flags.interior ? lbp3r_pkg::lbp_code(window_next) : window_next[4];
        result.last = flags.is_last;
    end

endmodule

`default_nettype wire

[src/lbp3r_out_fifo.sv]
// small result queue decoupling the pipeline from the output stall
`default_nettype none

module lbp3r_out_fifo (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  lbp3r_pkg::out_item_t                 push_item,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [lbp3r_pkg::PIXEL_W-1:0]        code,
    output logic                                 last,
    output logic [lbp3r_pkg::FIFO_CNT_W-1:0]     count
);

    lbp3r_pkg::out_item_t mem [lbp3r_pkg::FIFO_DEPTH];
    logic [lbp3r_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [lbp3r_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [lbp3r_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                             pop;
    lbp3r_pkg::out_item_t             head;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign head      = mem[rd_ptr_reg];
    assign code      = head.code;
    assign last      = head.last;
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + lbp3r_pkg::FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + lbp3r_pkg::FIFO_PTR_W'(1);
            count_reg <= count_reg + lbp3r_pkg::FIFO_CNT_W'(push)
                         - lbp3r_pkg::FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

[src/lbp_3x3_raster_operator_core.sv]
// top level of the 3x3 local binary pattern raster operator
// 3x3 local binary pattern operator on a raster stream of 8-bit gray pixels. one
// transaction is taken every clock when the output side keeps up: the line store
// is read when a pixel is accepted and written in the following cycle, the window
// shifts and the eight compares run in that same cycle, and the result goes into a
// four-entry output queue. a result reaches the queue through the entry stage
// register and leaves it when not stalled; in stream terms the result for a pixel
// comes with the transaction width+1 positions later, so after the last pixel of a
// frame width+1 flush transactions drain the tail (a flush at stream position zero
// is dropped). pixels beyond width*height act as flushes. interior pixels give the
// pattern code (bit 7 nw, then n, ne, e, se, s, sw, bit 0 w; set when the
// neighbour is strictly greater than the centre); first/last row and column pass
// the source value, and last marks the final pixel of the frame, after which the
// stream restarts. the line store is one MAX_WIDTH x 16-bit memory with one read
// and one write per cycle; it needs no clearing pass after reset. configuration
// writes (index 0 image_width, index 1 image_height) are always taken, restart the
// stream and must only be issued while the block is idle; width 0 acts as 1,
// widths above MAX_WIDTH act as MAX_WIDTH, height 0 acts as 1
`default_nettype none

module lbp_3x3_raster_operator_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lbp3r_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lbp3r_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lbp3r_pkg::PIXEL_W-1:0]     pixel,
    input  wire logic                              flush,
    // result output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lbp3r_pkg::PIXEL_W-1:0]          code,
    output logic                                   last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                              step;
    logic [COL_W-1:0]                  step_addr;
    logic                              s1_valid;
    logic [COL_W-1:0]                  s1_addr;
    logic [lbp3r_pkg::PIXEL_W-1:0]     s1_pixel;
    lbp3r_pkg::pix_flags_t             s1_flags;
    lbp3r_pkg::col_word_t              col_word;
    logic                              push;
    lbp3r_pkg::out_item_t              result;
    logic [lbp3r_pkg::FIFO_CNT_W-1:0]  fifo_count;
    logic                              s1_emit;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // hold input while the queue could not absorb what is already in flight
    assign s1_emit  = s1_valid && s1_flags.emit;
    assign in_stall = (fifo_count + lbp3r_pkg::FIFO_CNT_W'(s1_emit))
                      >= lbp3r_pkg::FIFO_CNT_W'(lbp3r_pkg::FIFO_DEPTH);

    // stream position, frame size and the entry stage
    lbp3r_stream_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .flush     (flush),
        .step      (step),
        .step_addr (step_addr),
        .s1_valid  (s1_valid),
        .s1_addr   (s1_addr),
        .s1_pixel  (s1_pixel),
        .s1_flags  (s1_flags)
    );

    // previous two rows, read at accept, written back in the following cycle
    lbp3r_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (step),
        .rd_addr  (step_addr),
        .wr_en    (s1_valid),
        .wr_addr  (s1_addr),
        .wr_pixel (s1_pixel),
        .col_word (col_word)
    );

    // window shift and eight compares
    lbp3r_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_valid),
        .flags    (s1_flags),
        .pixel    (s1_pixel),
        .col_word (col_word),
        .push     (push),
        .result   (result)
    );

    // result queue
    lbp3r_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .code      (code),
        .last      (last),
        .count     (fifo_count)
    );

`ifndef SYNTHESIS
    // the stall must keep the queue from ever taking a result while full
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fifo_count != lbp3r_pkg::FIFO_CNT_W'(lbp3r_pkg::FIFO_DEPTH))
                  || (out_valid && !out_stall)))
        else $error("result pushed into a full output queue");

    // every stepped pixel reaches the window stage in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> s1_valid)
        else $error("stepped pixel lost before the window stage");

    // results only come from a pixel in the window stage
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s1_valid)
        else $error("result produced without a pixel in the window stage");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the 3x3 local binary pattern raster operator core
module testbench;
    import lbp3r_pkg::*;

    // line store depth of the block, also the width clamp
    localparam int LINE_MAX = 1024;
    // register indexes past the two real registers, the block ignores them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;
    // length of the forced output hold-off
    localparam int HOLD_CYCLES = 80;
    // cycles with no transaction anywhere before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // quiet cycles after the last result: pipeline plus output queue with margin
    localparam int SETTLE_CYCLES = 10;
    // pixels offered at the start of a clamped wide line before the next restart
    localparam int WIDE_START_ITEMS = 24;

    // predicts the code stream of the operator and checks the block against it
    class raster_code_tracker;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        logic [PIXEL_W-1:0]  line_mem [2*LINE_MAX];
        logic [PIXEL_W-1:0]  win [9];
        int unsigned         in_col, in_row, out_col, out_row;
        out_item_t           code_queue [$];
        int unsigned         failures, codes_checked, frames_done, interior_codes;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            failures = 0;
            codes_checked = 0;
            frames_done = 0;
            interior_codes = 0;
            rewind_stream();
        endfunction

        function void rewind_stream();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH)
            begin
                width_reg = data[WIDTH_W-1:0];
                rewind_stream();
            end
            else if (idx == CFG_IMAGE_HEIGHT)
            begin
                height_reg = data[HEIGHT_W-1:0];
                rewind_stream();
            end
        endfunction

        // neighbours in bit order nw, n, ne, e, se, s, sw, w against the centre
        function logic [PIXEL_W-1:0] window_pattern();
            int order [8] = '{0, 1, 2, 5, 8, 7, 6, 3};
            logic [PIXEL_W-1:0] bits;
            bits = '0;
            for (int k = 0; k < 8; k++)
                bits[7-k] = win[order[k]] > win[4];
            return bits;
        endfunction

        // one accepted input transaction, queues the code it completes if any
        function void take_item(logic [PIXEL_W-1:0] pix, logic is_flush);
            int unsigned w, h, col;
            logic [PIXEL_W-1:0] v, top, mid;
            bit interior, final_px;
            out_item_t item;
            w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            if (is_flush && in_row == 0 && in_col == 0)
                return;
            v = (is_flush || in_row >= h) ? '0 : pix;
            col = in_col % LINE_MAX;
            top = line_mem[LINE_MAX + col];
            mid = line_mem[col];
            for (int r = 0; r < 3; r++)
            begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = v;
            line_mem[LINE_MAX + col] = mid;
            line_mem[col] = v;
            if (in_row >= 2 || (in_row == 1 && in_col >= 1))
            begin
                interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
                final_px = out_row + 1 >= h && out_col + 1 >= w;
                item.code = interior ? window_pattern() : win[4];
                item.last = final_px;
                code_queue.push_back(item);
                if (interior)
                    interior_codes++;
                if (final_px)
                begin
                    rewind_stream();
                    return;
                end
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        endfunction

        // one accepted result transaction against the oldest prediction
        function void check_code(logic [PIXEL_W-1:0] got_code, logic got_last);
            out_item_t want;
            if (code_queue.size() == 0)
            begin
                $error("result with nothing pending: code %0d last %0d", got_code, got_last);
                failures++;
                return;
            end
            want = code_queue.pop_front();
            codes_checked++;
            if (got_code !== want.code)
            begin
                $error("code mismatch: expected %0d, actual %0d", want.code, got_code);
                failures++;
            end
            if (got_last !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, got_last);
                failures++;
            end
            if (want.last)
                frames_done++;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel;
    logic                   flush;
    logic                   out_valid;
    logic                   out_stall;
    logic [PIXEL_W-1:0]     code;
    logic                   last;

    raster_code_tracker tracker = new();

    // idle percentages of the two sides, changed per phase by the stimulus
    int          send_gap_pct;
    int          recv_stall_pct;
    // forced hold-offs asked by the stimulus and taken by the receiver
    int          hold_requests = 0;
    int          holds_done = 0;
    // pixel and drain transactions sent as part of frames
    int unsigned items_sent = 0;
    // effective geometry of the frame currently configured
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned quiet_cycles = 0;

    lbp_3x3_raster_operator_core #(
        .MAX_WIDTH(LINE_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel    (pixel),
        .flush    (flush),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .code     (code),
        .last     (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: every handshake is sampled on the edge that completes it, using
    // the values from before the edge so drive order does not matter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_code(code, last);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                tracker.take_item(pixel, flush);
            if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hang detection: too long without any transaction on any channel
    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("watchdog: no transaction for %0d cycles, %0d results still pending",
                 STALL_LIMIT, tracker.code_queue.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // output side: random stall, or a long hold-off when one is asked for
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                out_stall <= 1'b1;
                // keep the output blocked so the queue fills and the input backs up
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // pixel values biased toward near-equal neighbours and the extremes
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        logic [PIXEL_W-1:0] v;
        case ($urandom_range(3))
            0: v = PIXEL_W'($urandom_range(101, 99));
            1: v = $urandom_range(1) ? 8'hFF : 8'h00;
            default: v = PIXEL_W'($urandom_range(255));
        endcase
        return v;
    endfunction

    // one input transaction with random leading idle cycles; valid stays high after
    task automatic offer_item(input logic [PIXEL_W-1:0] p, input logic f);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        pixel <= p;
        flush <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // one register write; the caller lowers cfg_valid after the last one
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // stop offering, wait for every predicted code, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.code_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new geometry, written only with the block drained; both orders and the
    // ignored indexes show up at random
    task automatic configure(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
        settle();
        if ($urandom_range(1))
        begin
            write_cfg(CFG_IMAGE_WIDTH, wd);
            write_cfg(CFG_IMAGE_HEIGHT, hd);
        end
        else
        begin
            write_cfg(CFG_IMAGE_HEIGHT, hd);
            write_cfg(CFG_IMAGE_WIDTH, wd);
        end
        if ($urandom_range(3) == 0)
            write_cfg($urandom_range(1) ? CFG_SPARE_HIGH : CFG_SPARE_LOW,
                      CFG_DATA_W'($urandom_range(4095)));
        cfg_valid <= 1'b0;
        // width is 11 bits wide in the block, zero acts as one, wide acts as the max
        frame_w = (wd[WIDTH_W-1:0] == 0) ? 1 :
                  ((wd[WIDTH_W-1:0] > LINE_MAX) ? LINE_MAX : wd[WIDTH_W-1:0]);
        frame_h = (hd == 0) ? 1 : hd;
    endtask

    // a whole frame: w*h pixels with the odd flush inside, then w+1 drain items
    // that mix flushes and pixels past the end of the frame
    task automatic send_frame(input int unsigned w, input int unsigned h, input int flush_pct);
        for (int unsigned n = 0; n < w * h; n++)
        begin
            // never flush at position zero, that one would be dropped
            if (n != 0 && $urandom_range(99) < flush_pct)
                offer_item(pick_pixel(), 1'b1);
            else
                offer_item(pick_pixel(), 1'b0);
        end
        for (int unsigned n = 0; n <= w; n++)
            offer_item(pick_pixel(), 1'($urandom_range(1)));
        items_sent += w * h + w + 1;
    endtask

    // mostly small random frames, sometimes back to back without a register write
    task automatic random_frames(input int unsigned goal);
        logic [CFG_DATA_W-1:0] wd, hd;
        while (items_sent < goal)
        begin
            if ($urandom_range(2) != 0)
            begin
                wd = ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(40, 11))
                                              : CFG_DATA_W'($urandom_range(10, 0));
                hd = CFG_DATA_W'($urandom_range(7, 0));
                configure(wd, hd);
            end
            // stray flush with the stream at rest, must be swallowed
            if ($urandom_range(5) == 0)
                offer_item(pick_pixel(), 1'b1);
            send_frame(frame_w, frame_h, 8);
        end
    endtask

    initial
    begin : stimulus
        // 4x3 frame: equal neighbours, extremes and a flush inside the bottom row
        logic [PIXEL_W-1:0] grid [12] = '{8'd0,   8'd255, 8'd7,   8'd200,
                                         8'd255, 8'd128, 8'd128, 8'd0,
                                         8'd60,  8'd129, 8'd127, 8'd255};
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        pixel <= '0;
        flush <= 1'b0;
        send_gap_pct = 34;
        recv_stall_pct = 62;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small frame with both interior centres, then the 1x1 corner
        configure(12'd4, 12'd3);
        offer_item(8'hA5, 1'b1);
        for (int i = 0; i < 12; i++)
            offer_item(grid[i], i == 8);
        offer_item(8'd0, 1'b1);
        offer_item(8'd77, 1'b0);
        offer_item(8'd0, 1'b1);
        offer_item(8'd0, 1'b1);
        offer_item(8'd255, 1'b0);
        // zero width and zero height both act as one
        configure(12'd0, 12'd0);
        offer_item(8'd255, 1'b0);
        offer_item(8'd0, 1'b1);
        offer_item(8'd3, 1'b0);

        // receiver stalls more often than the sender idles
        random_frames(140);

        // swapped, with one long output hold-off while the sender keeps offering
        send_gap_pct = 62;
        recv_stall_pct = 34;
        configure(12'd8, 12'd5);
        send_gap_pct = 0;
        hold_requests++;
        send_frame(frame_w, frame_h, 0);
        send_gap_pct = 62;
        random_frames(280);

        // full rate on both sides
        send_gap_pct = 0;
        recv_stall_pct = 0;
        random_frames(400);
        // start of a line through the width clamp, cut short by a restart
        configure(12'hFFF, 12'd3);
        for (int i = 0; i < WIDE_START_ITEMS; i++)
            offer_item(pick_pixel(), 1'b0);
        items_sent += WIDE_START_ITEMS;
        // width value whose top bit falls outside the register, leaving one column
        configure(12'h801, 12'd6);
        send_frame(frame_w, frame_h, 2);

        settle();
        $display("checked %0d codes over %0d frames, %0d of them interior patterns",
                 tracker.codes_checked, tracker.frames_done, tracker.interior_codes);
        $display("%0d frame transactions, geometries up to 40x7 plus clamped and truncated widths",
                 items_sent);
        if (tracker.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/lbp3r_pkg.sv
src/lbp3r_stream_ctrl.sv
src/lbp3r_line_store.sv
src/lbp3r_window.sv
src/lbp3r_out_fifo.sv
src/lbp_3x3_raster_operator_core.sv
tb/sv/testbench.sv
